// ===== design/grpm_pkg.sv =====
// Shared constants, codes, types and helpers for the generational region pool manager.
package grpm_pkg;

	localparam int REGION_COUNT = 64;
	localparam int IDX_W        = $clog2(REGION_COUNT);
	localparam int CNT_W        = $clog2(REGION_COUNT + 1);
	localparam int KIND_W       = 3;
	localparam int AGE_W        = 8;
	localparam int OP_W         = 2;
	localparam int STATUS_W     = 2;
	localparam int LIMIT_W      = 7;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 8;
	localparam int NUM_KINDS    = 5;
	localparam int KSEL_W       = $clog2(NUM_KINDS);

	localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
	localparam logic [OP_W-1:0] OP_PROMOTE = 2'd2;
	localparam logic [OP_W-1:0] OP_AGE     = 2'd3;

	localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_YOUNG     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SURVIVOR  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_OLD       = 3'd3;
	localparam logic [KIND_W-1:0] KIND_HUMONGOUS = 3'd4;
	localparam logic [KIND_W-1:0] KIND_PINNED    = 3'd5;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_REGION_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_YOUNG_AGE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SURVIVOR_AGE   = 2'd2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET        = 7'd64;
	localparam logic [AGE_W-1:0]   YOUNG_AGE_RESET    = 8'd1;
	localparam logic [AGE_W-1:0]   SURVIVOR_AGE_RESET = 8'd15;

	typedef struct packed {
		logic accept;
		logic exec;
	} grpm_cmd_t;

	function automatic logic [IDX_W-1:0] grpm_next_ptr(input logic [IDX_W-1:0] ptr);
		return (ptr == IDX_W'(REGION_COUNT - 1)) ? '0 : ptr + 1'b1;
	endfunction

endpackage

// ===== design/grpm_ctrl.sv =====
// Controller: sequences table read and update for each request and owns the result valid.
module grpm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output grpm_pkg::grpm_cmd_t cmd
);
	import grpm_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.accept = in_valid && in_ready;
	assign cmd.exec   = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd.exec) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("update did not present a result");

	a_stall_holds_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) && out_valid_q && !out_ready |=> (state_q == ST_EXEC))
		else $error("update overran a result that was not taken");

	a_no_back_to_back_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !cmd.accept)
		else $error("request accepted before the previous one was applied");

endmodule

// ===== design/grpm_datapath.sv =====
// Datapath: region tables, free queue, counters, configuration and result register.
module grpm_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  grpm_pkg::grpm_cmd_t                  cmd,
	input  logic                                 cfg_write,
	input  logic [grpm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [grpm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [grpm_pkg::OP_W-1:0]            operation,
	input  logic [grpm_pkg::KIND_W-1:0]          region_kind,
	input  logic [grpm_pkg::IDX_W-1:0]           region_index,
	output logic [grpm_pkg::STATUS_W-1:0]        status,
	output logic [grpm_pkg::IDX_W-1:0]           result_index,
	output logic [grpm_pkg::KIND_W-1:0]          result_kind,
	output logic [grpm_pkg::AGE_W-1:0]           result_age,
	output logic                                 was_promoted,
	output logic [grpm_pkg::CNT_W-1:0]           created_count,
	output logic [grpm_pkg::CNT_W-1:0]           free_count,
	output logic [grpm_pkg::CNT_W-1:0]           young_count,
	output logic [grpm_pkg::CNT_W-1:0]           survivor_count,
	output logic [grpm_pkg::CNT_W-1:0]           old_count,
	output logic [grpm_pkg::CNT_W-1:0]           humongous_count,
	output logic [grpm_pkg::CNT_W-1:0]           pinned_count
);
	import grpm_pkg::*;

	logic [KIND_W-1:0] kind_mem [REGION_COUNT];
	logic [AGE_W-1:0]  age_mem  [REGION_COUNT];
	logic [IDX_W-1:0]  fq_mem   [REGION_COUNT];

	logic [LIMIT_W-1:0] region_limit_q;
	logic [AGE_W-1:0]   young_age_q;
	logic [AGE_W-1:0]   survivor_age_q;

	logic [OP_W-1:0]   op_q;
	logic [KIND_W-1:0] kind_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  fq_rd_q;
	logic [KIND_W-1:0] kind_rd_q;
	logic [AGE_W-1:0]  age_rd_q;

	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] created_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] kcnt_q [NUM_KINDS];

	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]    r_index_q;
	logic [KIND_W-1:0]   r_kind_q;
	logic [AGE_W-1:0]    r_age_q;
	logic                promoted_q;
	logic [CNT_W-1:0]    created_out_q;
	logic [CNT_W-1:0]    fill_out_q;
	logic [CNT_W-1:0]    kcnt_out_q [NUM_KINDS];

	logic [CNT_W-1:0]    limit_eff;
	logic                have_free;
	logic                can_create;
	logic [KIND_W-1:0]   alloc_kind;
	logic [AGE_W-1:0]    age_inc;
	logic                bad_index;
	logic                go;
	logic                got;
	logic [STATUS_W-1:0] nxt_status;
	logic [IDX_W-1:0]    nxt_index;
	logic [KIND_W-1:0]   nxt_kind;
	logic [AGE_W-1:0]    nxt_age;
	logic                nxt_promoted;
	logic                tbl_we;
	logic [IDX_W-1:0]    tbl_addr;
	logic                enq;
	logic [IDX_W-1:0]    enq_id;
	logic                pop;
	logic                create;
	logic                inc_en;
	logic [KSEL_W-1:0]   inc_sel;
	logic                dec_en;
	logic [KSEL_W-1:0]   dec_sel;
	logic [CNT_W-1:0]    fill_nxt;
	logic [CNT_W-1:0]    created_nxt;
	logic [CNT_W-1:0]    kcnt_nxt [NUM_KINDS];
	logic [CNT_W+2:0]    pool_sum;

	always_comb begin
		limit_eff  = (int'(region_limit_q) > REGION_COUNT) ? CNT_W'(REGION_COUNT)
			: CNT_W'(region_limit_q);
		have_free  = (fill_q != '0);
		can_create = (created_q < limit_eff);
		alloc_kind = (kind_q inside {[KIND_YOUNG:KIND_PINNED]}) ? kind_q : KIND_EMPTY;
		age_inc    = (age_rd_q == AGE_MAX) ? age_rd_q : age_rd_q + 1'b1;
		bad_index  = (CNT_W'(idx_q) >= created_q) || (kind_rd_q == KIND_EMPTY);

		go           = 1'b0;
		got          = 1'b0;
		nxt_status   = STATUS_OK;
		nxt_index    = '0;
		nxt_kind     = KIND_EMPTY;
		nxt_age      = '0;
		nxt_promoted = 1'b0;
		tbl_we       = 1'b0;
		tbl_addr     = idx_q;
		enq          = 1'b0;
		enq_id       = idx_q;
		pop          = 1'b0;
		create       = 1'b0;
		inc_en       = 1'b0;
		inc_sel      = '0;
		dec_en       = 1'b0;
		dec_sel      = '0;

		if (op_q == OP_ALLOC) begin
			if (have_free) begin
				got       = 1'b1;
				pop       = 1'b1;
				nxt_index = fq_rd_q;
			end else if (can_create) begin
				got       = 1'b1;
				create    = 1'b1;
				nxt_index = created_q[IDX_W-1:0];
			end
			if (!got) begin
				nxt_status = STATUS_EXHAUSTED;
				nxt_index  = '0;
			end else begin
				tbl_we   = 1'b1;
				tbl_addr = nxt_index;
				nxt_kind = alloc_kind;
				if (alloc_kind != KIND_EMPTY) begin
					inc_en  = 1'b1;
					inc_sel = KSEL_W'(alloc_kind - 1'b1);
				end else begin
					enq    = 1'b1;
					enq_id = nxt_index;
				end
			end
		end else begin
			nxt_index = idx_q;
			if (bad_index) begin
				nxt_status = STATUS_BAD_INDEX;
			end else begin
				tbl_we   = 1'b1;
				nxt_kind = kind_rd_q;
				nxt_age  = age_rd_q;
				case (op_q)
					OP_FREE: begin
						dec_en   = 1'b1;
						dec_sel  = KSEL_W'(kind_rd_q - 1'b1);
						nxt_kind = KIND_EMPTY;
						nxt_age  = '0;
						enq      = 1'b1;
					end
					OP_PROMOTE: begin
						go = (kind_rd_q == KIND_YOUNG) || (kind_rd_q == KIND_SURVIVOR);
					end
					OP_AGE: begin
						nxt_age = age_inc;
						go = ((kind_rd_q == KIND_YOUNG) && (age_inc > young_age_q))
							|| ((kind_rd_q == KIND_SURVIVOR) && (age_inc > survivor_age_q));
					end
					default: begin
						go = 1'b0;
					end
				endcase
				if (go) begin
					dec_en       = 1'b1;
					dec_sel      = KSEL_W'(kind_rd_q - 1'b1);
					nxt_kind     = (kind_rd_q == KIND_YOUNG) ? KIND_SURVIVOR : KIND_OLD;
					inc_en       = 1'b1;
					inc_sel      = KSEL_W'(nxt_kind - 1'b1);
					nxt_promoted = 1'b1;
				end
			end
		end

		fill_nxt    = fill_q - CNT_W'(pop) + CNT_W'(enq);
		created_nxt = created_q + CNT_W'(create);
		for (int i = 0; i < NUM_KINDS; i++) begin
			kcnt_nxt[i] = kcnt_q[i]
				+ CNT_W'(inc_en && (inc_sel == KSEL_W'(i)))
				- CNT_W'(dec_en && (dec_sel == KSEL_W'(i)));
		end

		pool_sum = (CNT_W+3)'(fill_q);
		for (int i = 0; i < NUM_KINDS; i++) begin
			pool_sum = pool_sum + (CNT_W+3)'(kcnt_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q      <= operation;
			kind_q    <= region_kind;
			idx_q     <= region_index;
			fq_rd_q   <= fq_mem[head_q];
			kind_rd_q <= kind_mem[region_index];
			age_rd_q  <= age_mem[region_index];
		end
		if (cmd.exec && tbl_we) begin
			kind_mem[tbl_addr] <= nxt_kind;
			age_mem[tbl_addr]  <= nxt_age;
		end
		if (cmd.exec && enq) begin
			fq_mem[tail_q] <= enq_id;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q      <= nxt_status;
			r_index_q     <= nxt_index;
			r_kind_q      <= nxt_kind;
			r_age_q       <= nxt_age;
			promoted_q    <= nxt_promoted;
			created_out_q <= created_nxt;
			fill_out_q    <= fill_nxt;
			for (int i = 0; i < NUM_KINDS; i++) begin
				kcnt_out_q[i] <= kcnt_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_limit_q <= LIMIT_RESET;
			young_age_q    <= YOUNG_AGE_RESET;
			survivor_age_q <= SURVIVOR_AGE_RESET;
			head_q         <= '0;
			tail_q         <= '0;
			created_q      <= '0;
			fill_q         <= '0;
			for (int i = 0; i < NUM_KINDS; i++) begin
				kcnt_q[i] <= '0;
			end
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_REGION_LIMIT: region_limit_q <= cfg_data[LIMIT_W-1:0];
					CFG_YOUNG_AGE:    young_age_q    <= cfg_data[AGE_W-1:0];
					CFG_SURVIVOR_AGE: survivor_age_q <= cfg_data[AGE_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.exec) begin
				if (pop) begin
					head_q <= grpm_next_ptr(head_q);
				end
				if (enq) begin
					tail_q <= grpm_next_ptr(tail_q);
				end
				created_q <= created_nxt;
				fill_q    <= fill_nxt;
				for (int i = 0; i < NUM_KINDS; i++) begin
					kcnt_q[i] <= kcnt_nxt[i];
				end
			end
		end
	end

	assign status          = status_q;
	assign result_index    = r_index_q;
	assign result_kind     = r_kind_q;
	assign result_age      = r_age_q;
	assign was_promoted    = promoted_q;
	assign created_count   = created_out_q;
	assign free_count      = fill_out_q;
	assign young_count     = kcnt_out_q[0];
	assign survivor_count  = kcnt_out_q[1];
	assign old_count       = kcnt_out_q[2];
	assign humongous_count = kcnt_out_q[3];
	assign pinned_count    = kcnt_out_q[4];

	a_pool_conserved: assert property (@(posedge clk) disable iff (!arst_n)
		pool_sum == (CNT_W+3)'(created_q))
		else $error("free and typed regions do not add up to the created regions");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= created_q)
		else $error("free queue holds more entries than regions created");

	a_counts_stable_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> $stable(created_q) && $stable(fill_q) && $stable(head_q))
		else $error("pool state changed without an update");

endmodule

// ===== design/generational_region_pool_manager.sv =====
// Top level of the generational region pool manager.
// Each request (alloc, free, promote or age) first reads the kind and age tables and the
// head of the free queue, then applies the update and loads the result register. A new
// request is accepted while the previous result waits to be transferred, but its update
// waits until that transfer, so a stalled output holds back the update step. Every result
// carries the created, free and per-kind counts after the request.
// The tables hold no reset value; no clearing pass is needed after reset.
module generational_region_pool_manager (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [grpm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [grpm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [grpm_pkg::OP_W-1:0]            operation,
	input  logic [grpm_pkg::KIND_W-1:0]          region_kind,
	input  logic [grpm_pkg::IDX_W-1:0]           region_index,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [grpm_pkg::STATUS_W-1:0]        status,
	output logic [grpm_pkg::IDX_W-1:0]           result_index,
	output logic [grpm_pkg::KIND_W-1:0]          result_kind,
	output logic [grpm_pkg::AGE_W-1:0]           result_age,
	output logic                                 was_promoted,
	output logic [grpm_pkg::CNT_W-1:0]           created_count,
	output logic [grpm_pkg::CNT_W-1:0]           free_count,
	output logic [grpm_pkg::CNT_W-1:0]           young_count,
	output logic [grpm_pkg::CNT_W-1:0]           survivor_count,
	output logic [grpm_pkg::CNT_W-1:0]           old_count,
	output logic [grpm_pkg::CNT_W-1:0]           humongous_count,
	output logic [grpm_pkg::CNT_W-1:0]           pinned_count
);
	import grpm_pkg::*;

	grpm_cmd_t cmd;

	grpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	grpm_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.operation       (operation),
		.region_kind     (region_kind),
		.region_index    (region_index),
		.status          (status),
		.result_index    (result_index),
		.result_kind     (result_kind),
		.result_age      (result_age),
		.was_promoted    (was_promoted),
		.created_count   (created_count),
		.free_count      (free_count),
		.young_count     (young_count),
		.survivor_count  (survivor_count),
		.old_count       (old_count),
		.humongous_count (humongous_count),
		.pinned_count    (pinned_count)
	);

endmodule
